/* hw/rtl/swm_pkg.sv */
// shared constants, types and window length decode for the sliding window median
package swm_pkg;

	localparam int WINDOW_DEPTH = 25;
	localparam int RANK_BITS    = 5;
	localparam int SEL_BITS     = 3;

	localparam logic [SEL_BITS-1:0] SEL_W3    = 3'd0;
	localparam logic [SEL_BITS-1:0] SEL_W5    = 3'd1;
	localparam logic [SEL_BITS-1:0] SEL_W7    = 3'd2;
	localparam logic [SEL_BITS-1:0] SEL_W9    = 3'd3;
	localparam logic [SEL_BITS-1:0] SEL_W25   = 3'd4;
	localparam logic [SEL_BITS-1:0] SEL_RESET = SEL_W25;

	typedef logic [RANK_BITS-1:0] rank_t;

	typedef struct packed {
		logic [WINDOW_DEPTH-1:0] hit;
	} swm_stat_t;

	// unused codes fall back to the longest window
	function automatic rank_t win_len(logic [SEL_BITS-1:0] sel);
		rank_t len;
		case (sel)
			SEL_W3:  len = rank_t'(3);
			SEL_W5:  len = rank_t'(5);
			SEL_W7:  len = rank_t'(7);
			SEL_W9:  len = rank_t'(9);
			SEL_W25: len = rank_t'(WINDOW_DEPTH);
			default: len = rank_t'(WINDOW_DEPTH);
		endcase
		return len;
	endfunction

endpackage

/* hw/rtl/swm_rank_select.sv */
// rank counting median selector over the delay line
module swm_rank_select import swm_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic signed [SAMPLE_BITS-1:0] win [WINDOW_DEPTH],
	input  rank_t                         len,
	output logic signed [SAMPLE_BITS-1:0] median,
	output swm_stat_t                     stat
);

	localparam int CNT_W    = 32;
	localparam int POP_BITS = 6;

	// balanced adder tree, five levels
	function automatic logic [POP_BITS-1:0] popcount32(logic [CNT_W-1:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int k = 0; k < 16; k++) l1[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
		for (int k = 0; k < 8; k++)  l2[k] = {1'b0, l1[2*k]} + {1'b0, l1[2*k+1]};
		for (int k = 0; k < 4; k++)  l3[k] = {1'b0, l2[2*k]} + {1'b0, l2[2*k+1]};
		for (int k = 0; k < 2; k++)  l4[k] = {1'b0, l3[2*k]} + {1'b0, l3[2*k+1]};
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

	logic [WINDOW_DEPTH-1:0] in_win;
	logic [CNT_W-1:0]        less [WINDOW_DEPTH];
	logic [POP_BITS-1:0]     cnt  [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] hit;
	rank_t                   half;

	assign half = len >> 1;

	always_comb begin
		for (int j = 0; j < WINDOW_DEPTH; j++) begin
			in_win[j] = rank_t'(j) < len;
		end
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			less[i] = '0;
			// equal values are ordered by position so every rank is distinct
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				if (j != i) begin
					less[i][j] = in_win[j] &&
						((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)));
				end
			end
			cnt[i] = popcount32(less[i]);
			hit[i] = in_win[i] && (cnt[i][RANK_BITS-1:0] == half);
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			median = median | ({SAMPLE_BITS{hit[i]}} & win[i]);
		end
	end

	assign stat.hit = hit;

endmodule

/* hw/rtl/sliding_window_median.sv */
// sliding window median filter top level
// an accepted sample is registered into the delay line, then its median into the output register
// throughput: one sample per cycle while the output is not stalled, set by the single rank-and-select stage
// the sample stall rises only while both pipeline registers hold and output is stalled
// reset clears the delay line to zeros, empties the pipeline, selects the 25 window
module sliding_window_median import swm_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [SEL_BITS-1:0]           cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          median_valid,
	input  logic                          median_stall,
	output logic signed [SAMPLE_BITS-1:0] median_value
);

	logic signed [SAMPLE_BITS-1:0] window_s1 [WINDOW_DEPTH];
	logic                          valid_s1;
	logic                          valid_s2;
	logic signed [SAMPLE_BITS-1:0] median_s2;
	logic [SEL_BITS-1:0]           window_select_q;

	logic                          out_ready;
	logic                          in_acc;
	logic signed [SAMPLE_BITS-1:0] median_c;
	swm_stat_t                     stat;

	assign out_ready    = !valid_s2 || !median_stall;
	assign sample_stall = valid_s1 && !out_ready;
	assign in_acc       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_select_q <= SEL_RESET;
		end else if (cfg_we) begin
			window_select_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) window_s1[i] <= '0;
		end else if (in_acc) begin
			window_s1[0] <= sample;
			for (int i = 1; i < WINDOW_DEPTH; i++) window_s1[i] <= window_s1[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
			if (out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			median_s2 <= median_c;
		end
	end

	swm_rank_select #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_rank (
		.win    (window_s1),
		.len    (win_len(window_select_q)),
		.median (median_c),
		.stat   (stat)
	);

	assign median_valid = valid_s2;
	assign median_value = median_s2;

`ifndef SYNTHESIS
	a_single_median: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot(stat.hit))
		else $error("median selector did not pick exactly one entry");

	a_shift_line: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (window_s1[1] == $past(window_s1[0])) && (window_s1[0] == $past(sample)))
		else $error("delay line did not shift on an accepted sample");

	a_stage_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted sample lost before the select stage");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_ready) |=> valid_s2 && (median_s2 == $past(median_c)))
		else $error("select stage result not moved to the output register");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && median_stall) |-> sample_stall)
		else $error("sample taken while the pipeline was full");
`endif

endmodule

/* tb/tb.sv */
// testbench for the sliding window median filter
`timescale 1ns / 100ps

module tb;
	import swm_pkg::*;

	localparam int SAMPLE_BITS = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [SEL_BITS-1:0] SEL_SPARE_LO = 3'd5;
	localparam logic [SEL_BITS-1:0] SEL_SPARE_MID = 3'd6;
	localparam logic [SEL_BITS-1:0] SEL_SPARE_HI = 3'd7;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [SEL_BITS-1:0] cfg_data = SEL_RESET;
	logic                sample_valid = 1'b0;
	logic                sample_stall;
	sample_t             sample = '0;
	logic                median_valid;
	logic                median_stall = 1'b0;
	sample_t             median_value;

	sample_t             history [WINDOW_DEPTH];
	logic [SEL_BITS-1:0] win_code = SEL_RESET;
	sample_t             medians_due [$];
	int                  errors = 0;
	bit                  idling = 1'b1;
	int                  stall_hold = 0;
	int                  quiet_cycles = 0;

	sliding_window_median #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.median_valid(median_valid),
		.median_stall(median_stall),
		.median_value(median_value)
	);

	always #10 clk = ~clk;

	function automatic int window_length(logic [SEL_BITS-1:0] code);
		case (code)
			SEL_W3:  return 3;
			SEL_W5:  return 5;
			SEL_W7:  return 7;
			SEL_W9:  return 9;
			default: return WINDOW_DEPTH;
		endcase
	endfunction

	function automatic sample_t median_of_newest(int n);
		sample_t sorted [WINDOW_DEPTH];
		sample_t key;
		int j;
		for (int i = 0; i < n; i++) begin
			key = history[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		return sorted[n/2];
	endfunction

	// shift the accepted sample in and queue the median it must produce
	function automatic void record_median(sample_t v);
		for (int i = WINDOW_DEPTH - 1; i > 0; i--)
			history[i] = history[i-1];
		history[0] = v;
		medians_due.push_back(median_of_newest(window_length(win_code)));
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idling)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// extremes and narrow ranges so that ties are common
	function automatic sample_t random_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return sample_t'(16'h7fff);
			1:       return sample_t'(16'h8000);
			2, 3:    return sample_t'($urandom_range(0, 8) - 4);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_sample(input sample_t v);
		int gap;
		bit took;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= v;
		do begin
			@(negedge clk);
			took = sample_valid && !sample_stall;
			@(posedge clk);
		end while (!took);
		record_median(v);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (medians_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [SEL_BITS-1:0] code);
		wait_drained();
		cfg_data <= code;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_code = code;
	endtask

	// default 25 window straight after reset, so the zeros dominate
	task automatic test_reset_window();
		send_sample(sample_t'(16'h7fff));
		send_sample(sample_t'(16'h8000));
		send_sample(sample_t'(16'h0000));
		send_sample(sample_t'(16'hffff));
		send_sample(sample_t'(16'h0001));
		send_sample(sample_t'(16'h5555));
		send_sample(sample_t'(16'haaaa));
	endtask

	// short windows, spare codes, ties, and length changes applied to held samples
	task automatic test_window_codes();
		write_window(SEL_W3);
		send_sample(sample_t'(16'h8000));
		send_sample(sample_t'(16'h8000));
		send_sample(sample_t'(16'h7fff));
		write_window(SEL_W5);
		send_sample(sample_t'(16'h0001));
		write_window(SEL_W9);
		send_sample(sample_t'(16'h0002));
		write_window(SEL_SPARE_LO);
		send_sample(sample_t'(16'h7fff));
		write_window(SEL_SPARE_MID);
		send_sample(sample_t'(16'hfffe));
		write_window(SEL_SPARE_HI);
		send_sample(sample_t'(16'h0003));
		write_window(SEL_W7);
		send_sample(sample_t'(16'h0003));
		send_sample(sample_t'(16'h0003));
		send_sample(sample_t'(16'h8000));
	endtask

	task automatic test_random_windows();
		logic [SEL_BITS-1:0] code;
		for (int phase = 0; phase < 13; phase++) begin
			code = (phase < 8) ? SEL_BITS'(phase) : SEL_BITS'($urandom_range(0, 7));
			if (phase == 3)
				code = SEL_W25;
			write_window(code);
			// one phase runs at full rate with no back pressure
			idling = (phase != 5);
			for (int n = 0; n < 75; n++)
				send_sample(random_sample());
		end
		idling = 1'b1;
	endtask

	task automatic test_sender_pause();
		write_window(SEL_W9);
		for (int n = 0; n < 30; n++) begin
			send_sample(random_sample());
			if (n == 14)
				wait_drained();
		end
	endtask

	// output back pressure, with stretches of none
	always @(posedge clk) begin : out_stall_gen
		int r;
		if (!idling) begin
			median_stall <= 1'b0;
			stall_hold = 0;
		end else if (stall_hold != 0) begin
			stall_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				median_stall <= 1'b0;
				stall_hold = $urandom_range(0, 6);
			end else if (r < 93) begin
				median_stall <= 1'b1;
				stall_hold = $urandom_range(0, 3);
			end else begin
				median_stall <= 1'b1;
				stall_hold = $urandom_range(8, 40);
			end
		end
	end

	always @(negedge clk) begin : median_check
		sample_t due;
		if (arst_n && median_valid && !median_stall) begin
			if (medians_due.size() == 0) begin
				$error("median_value: no request expected, got %0d", median_value);
				errors++;
			end else begin
				due = medians_due.pop_front();
				if (median_value !== due) begin
					$error("median_value: expected %0d, got %0d", due, median_value);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((sample_valid && !sample_stall) || (median_valid && !median_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < WINDOW_DEPTH; i++)
			history[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_window_codes();
		test_random_windows();
		test_sender_pause();
		wait_drained();
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
